FILE: hw/rtl/gbfs_pkg.sv
// Shared constants, codes and control types of the grid search unit.
package gbfs_pkg;

   localparam int MAX_WIDTH  = 32;
   localparam int MAX_HEIGHT = 32;
   localparam int COORD_W    = 5;                       // log2 of MAX_WIDTH and MAX_HEIGHT
   localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
   localparam int IDX_W      = 2 * COORD_W;
   localparam int CNT_W      = IDX_W + 1;
   localparam int DIM_W      = 6;

   localparam logic [DIM_W-1:0] MAX_W_DIM    = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_H_DIM    = DIM_W'(MAX_HEIGHT);
   localparam logic [DIM_W-1:0] WIDTH_RESET  = 6'd30;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 6'd20;

   // csr register indexes
   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   // request actions
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // neighbor directions
   localparam logic [1:0] DIR_XP = 2'd0;
   localparam logic [1:0] DIR_XM = 2'd1;
   localparam logic [1:0] DIR_YP = 2'd2;
   localparam logic [1:0] DIR_YM = 2'd3;

   // visited flag plus the first step taken from the source toward this cell
   typedef struct packed {
      logic             visited;
      logic [IDX_W-1:0] first;
   } gbfs_par_type;

   localparam int PAR_W = $bits(gbfs_par_type);

   typedef struct packed {
      logic accept;    // take the request beat
      logic clr_all;   // reset sweep: blocked map and parent store
      logic clr_par;   // per-query sweep of the parent store
      logic seed;      // enqueue the source
      logic pop;       // read queue head
      logic cur_rd;    // latch current cell, read its parent entry
      logic cur_lat;   // latch current cell's first step
      logic nb_rd;     // read parent and blocked bit of the neighbor
      logic nb_chk;    // mark a free neighbor, enqueue it unless goal
      logic dir_inc;
      logic set_miss;
      logic set_self;
      logic set_hit;
      logic res_load;
   } gbfs_cmd_type;

   typedef struct packed {
      logic req_query;
      logic src_out;
      logic src_eq_goal;
      logic clr_last;
      logic q_empty;
      logic nb_ok;
      logic nb_free;
      logic nb_goal;
      logic dir_last;
      logic rsp_busy;
   } gbfs_stat_type;

endpackage

FILE: hw/rtl/grid_bfs_first_step_unit.sv
// Top level of the grid breadth-first search unit (first step of the path).
//
//   port group | dir | handshake        | beat carries
//   req_*      | in  | valid / stall    | action, cell_x, cell_y, blocked, goal_x, goal_y
//   rsp_*      | out | valid / stall    | found, step_x, step_y (one per query)
//   csr_*      | in  | valid / ready    | index (0 width, 1 height), 6-bit data
//
// A write beat is taken in the idle state. A query whose source is outside the grid
// or equals the goal goes from the check straight to the result; otherwise a sweep
// clears the parent store, the source is seeded, and each dequeued cell is popped,
// read and latched, then each direction is stepped, with a neighbor read and check
// per in-grid neighbor, as each store has a single read port. After reset a sweep
// clears the blocked map (req_stall high, csr writes still taken). One item is
// worked at a time; a stalled result only holds the next query at its end.
module grid_bfs_first_step_unit
   import gbfs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [COORD_W-1:0] req_cell_x,
   input  logic [COORD_W-1:0] req_cell_y,
   input  logic               req_blocked,
   input  logic [COORD_W-1:0] req_goal_x,
   input  logic [COORD_W-1:0] req_goal_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic [COORD_W-1:0] rsp_step_x,
   output logic [COORD_W-1:0] rsp_step_y,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [DIM_W-1:0]   csr_data
);

   gbfs_cmd_type  cmd;
   gbfs_stat_type stat;

   assign csr_ready = 1'b1;

   gbfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   gbfs_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_valid   (csr_valid & csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_action  (req_action),
      .req_cell_x  (req_cell_x),
      .req_cell_y  (req_cell_y),
      .req_blocked (req_blocked),
      .req_goal_x  (req_goal_x),
      .req_goal_y  (req_goal_y),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_found   (rsp_found),
      .rsp_step_x  (rsp_step_x),
      .rsp_step_y  (rsp_step_y)
   );

endmodule

FILE: hw/rtl/gbfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/gbfs_ctrl.sv
// Sequencer of the grid search: clearing sweeps, queue walk, result hand-off.
module gbfs_ctrl
   import gbfs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  gbfs_stat_type stat,
   output gbfs_cmd_type  cmd
);

   localparam logic [3:0] S_RCLR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_QCHK = 4'd2;
   localparam logic [3:0] S_PCLR = 4'd3;
   localparam logic [3:0] S_SEED = 4'd4;
   localparam logic [3:0] S_POP  = 4'd5;
   localparam logic [3:0] S_POPW = 4'd6;
   localparam logic [3:0] S_CUR  = 4'd7;
   localparam logic [3:0] S_NB   = 4'd8;
   localparam logic [3:0] S_CHK  = 4'd9;
   localparam logic [3:0] S_RES  = 4'd10;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RCLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_RCLR: begin
            cmd.clr_all = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.req_query) state_in = S_QCHK;
            end
         end
         S_QCHK: begin
            if (stat.src_out) begin
               cmd.set_miss = 1'b1;
               state_in     = S_RES;
            end else if (stat.src_eq_goal) begin
               cmd.set_self = 1'b1;
               state_in     = S_RES;
            end else begin
               state_in = S_PCLR;
            end
         end
         S_PCLR: begin
            cmd.clr_par = 1'b1;
            if (stat.clr_last) state_in = S_SEED;
         end
         S_SEED: begin
            cmd.seed = 1'b1;
            state_in = S_POP;
         end
         S_POP: begin
            if (stat.q_empty) begin
               cmd.set_miss = 1'b1;
               state_in     = S_RES;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_POPW;
            end
         end
         S_POPW: begin
            cmd.cur_rd = 1'b1;
            state_in   = S_CUR;
         end
         S_CUR: begin
            cmd.cur_lat = 1'b1;
            state_in    = S_NB;
         end
         S_NB: begin
            if (stat.nb_ok) begin
               cmd.nb_rd = 1'b1;
               state_in  = S_CHK;
            end else if (stat.dir_last) begin
               state_in = S_POP;
            end else begin
               cmd.dir_inc = 1'b1;
            end
         end
         S_CHK: begin
            cmd.nb_chk = 1'b1;
            if (stat.nb_free && stat.nb_goal) begin
               cmd.set_hit = 1'b1;
               state_in    = S_RES;
            end else if (stat.dir_last) begin
               state_in = S_POP;
            end else begin
               cmd.dir_inc = 1'b1;
               state_in    = S_NB;
            end
         end
         S_RES: begin
            if (!stat.rsp_busy) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_RCLR;
         end
      endcase
   end

endmodule

FILE: hw/rtl/gbfs_dp.sv
// Datapath of the grid search: config, blocked map, parent store, cell queue, result.
module gbfs_dp
   import gbfs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  gbfs_cmd_type       cmd,
   output gbfs_stat_type      stat,
   input  logic               csr_valid,
   input  logic               csr_index,
   input  logic [DIM_W-1:0]   csr_data,
   input  logic               req_action,
   input  logic [COORD_W-1:0] req_cell_x,
   input  logic [COORD_W-1:0] req_cell_y,
   input  logic               req_blocked,
   input  logic [COORD_W-1:0] req_goal_x,
   input  logic [COORD_W-1:0] req_goal_y,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic               rsp_found,
   output logic [COORD_W-1:0] rsp_step_x,
   output logic [COORD_W-1:0] rsp_step_y
);

   logic [DIM_W-1:0]   width_ff, height_ff;
   logic [COORD_W-1:0] sx_ff, sy_ff, gx_ff, gy_ff;
   logic [IDX_W-1:0]   clr_ff;
   logic [CNT_W-1:0]   head_ff, tail_ff;
   logic [IDX_W-1:0]   c_ff;
   logic               c_src_ff;
   logic [IDX_W-1:0]   first_c_ff;
   logic [1:0]         dir_ff;
   logic               pend_found_ff;
   logic [IDX_W-1:0]   pend_step_ff;
   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic [IDX_W-1:0]   rsp_step_ff;

   logic [DIM_W-1:0] w, h;
   logic [IDX_W-1:0] src_idx, goal_idx, n_idx, first_n;
   logic             goal_ok;
   logic [DIM_W-1:0] nx, ny;
   logic             nb_ok;
   logic [COORD_W-1:0] cx, cy;

   // rams
   logic               blk_we, blk_wd, blk_rd;
   logic [IDX_W-1:0]   blk_wa;
   logic               par_we, par_re;
   logic [IDX_W-1:0]   par_wa, par_ra;
   gbfs_par_type       par_wd, par_rd;
   logic               q_we;
   logic [IDX_W-1:0]   q_rd;

   assign w = (width_ff  > MAX_W_DIM) ? MAX_W_DIM : width_ff;
   assign h = (height_ff > MAX_H_DIM) ? MAX_H_DIM : height_ff;

   assign src_idx  = {sy_ff, sx_ff};
   assign goal_idx = {gy_ff, gx_ff};
   assign goal_ok  = ({1'b0, gx_ff} < w) && ({1'b0, gy_ff} < h);

   assign cx = c_ff[COORD_W-1:0];
   assign cy = c_ff[IDX_W-1:COORD_W];

   always_comb begin
      nx    = {1'b0, cx};
      ny    = {1'b0, cy};
      nb_ok = 1'b0;
      case (dir_ff)
         DIR_XP: begin
            nx    = {1'b0, cx} + 6'd1;
            nb_ok = nx < w;
         end
         DIR_XM: begin
            nx    = {1'b0, cx} - 6'd1;
            nb_ok = (cx != '0);
         end
         DIR_YP: begin
            ny    = {1'b0, cy} + 6'd1;
            nb_ok = ny < h;
         end
         DIR_YM: begin
            ny    = {1'b0, cy} - 6'd1;
            nb_ok = (cy != '0);
         end
         default: nb_ok = 1'b0;
      endcase
   end

   assign n_idx   = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
   assign first_n = c_src_ff ? n_idx : first_c_ff;

   // status
   assign stat.req_query   = (req_action == ACT_QUERY);
   assign stat.src_out     = ({1'b0, sx_ff} >= w) || ({1'b0, sy_ff} >= h);
   assign stat.src_eq_goal = (src_idx == goal_idx);
   assign stat.clr_last    = (clr_ff == IDX_W'(CELLS - 1));
   assign stat.q_empty     = (head_ff == tail_ff);
   assign stat.nb_ok       = nb_ok;
   assign stat.nb_free     = !par_rd.visited && !blk_rd;
   assign stat.nb_goal     = goal_ok && (n_idx == goal_idx);
   assign stat.dir_last    = (dir_ff == DIR_YM);
   assign stat.rsp_busy    = rsp_valid_ff && rsp_stall;

   // blocked map
   assign blk_we = cmd.clr_all || (cmd.accept && req_action == ACT_WRITE);
   assign blk_wa = cmd.clr_all ? clr_ff : {req_cell_y, req_cell_x};
   assign blk_wd = cmd.clr_all ? 1'b0 : req_blocked;

   gbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_blk_ram (
      .clock   (clock),
      .wr_en   (blk_we),
      .wr_addr (blk_wa),
      .wr_data (blk_wd),
      .rd_en   (cmd.nb_rd),
      .rd_addr (n_idx),
      .rd_data (blk_rd)
   );

   // parent store
   always_comb begin
      par_we = 1'b0;
      par_wa = n_idx;
      par_wd = '0;
      if (cmd.clr_all || cmd.clr_par) begin
         par_we = 1'b1;
         par_wa = clr_ff;
      end else if (cmd.seed) begin
         par_we = 1'b1;
         par_wa = src_idx;
         par_wd = '{visited: 1'b1, first: src_idx};
      end else if (cmd.nb_chk && stat.nb_free) begin
         par_we = 1'b1;
         par_wd = '{visited: 1'b1, first: first_n};
      end
   end

   assign par_re = cmd.cur_rd || cmd.nb_rd;
   assign par_ra = cmd.cur_rd ? q_rd : n_idx;

   gbfs_ram #(.WIDTH(PAR_W), .DEPTH(CELLS)) u_par_ram (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_wa),
      .wr_data (par_wd),
      .rd_en   (par_re),
      .rd_addr (par_ra),
      .rd_data (par_rd)
   );

   // cell queue
   assign q_we = cmd.seed
              || (cmd.nb_chk && stat.nb_free && !stat.nb_goal && tail_ff < CNT_W'(CELLS));

   gbfs_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (cmd.seed ? '0 : tail_ff[IDX_W-1:0]),
      .wr_data (cmd.seed ? src_idx : n_idx),
      .rd_en   (cmd.pop),
      .rd_addr (head_ff[IDX_W-1:0]),
      .rd_data (q_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         dir_ff       <= DIR_XP;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == REG_GRID_WIDTH) width_ff <= csr_data;
            else                             height_ff <= csr_data;
         end
         if (cmd.clr_all || cmd.clr_par) clr_ff <= clr_ff + 1'b1;
         if (cmd.seed) begin
            head_ff <= '0;
            tail_ff <= CNT_W'(1);
         end else begin
            if (cmd.pop) head_ff <= head_ff + 1'b1;
            if (q_we)    tail_ff <= tail_ff + 1'b1;
         end
         if (cmd.cur_lat)      dir_ff <= DIR_XP;
         else if (cmd.dir_inc) dir_ff <= dir_ff + 2'd1;
         if (cmd.res_load)                    rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sx_ff <= req_cell_x;
         sy_ff <= req_cell_y;
         gx_ff <= req_goal_x;
         gy_ff <= req_goal_y;
      end
      if (cmd.cur_rd) begin
         c_ff     <= q_rd;
         c_src_ff <= (q_rd == src_idx);
      end
      if (cmd.cur_lat) first_c_ff <= par_rd.first;
      if (cmd.set_miss) begin
         pend_found_ff <= 1'b0;
         pend_step_ff  <= '0;
      end else if (cmd.set_self) begin
         pend_found_ff <= 1'b1;
         pend_step_ff  <= src_idx;
      end else if (cmd.set_hit) begin
         pend_found_ff <= 1'b1;
         pend_step_ff  <= first_n;
      end
      if (cmd.res_load) begin
         rsp_found_ff <= pend_found_ff;
         rsp_step_ff  <= pend_step_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_step_x = rsp_step_ff[COORD_W-1:0];
   assign rsp_step_y = rsp_step_ff[IDX_W-1:COORD_W];

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff && tail_ff <= CNT_W'(CELLS))
      else $error("queue head passed tail or tail overflowed");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result loaded over a stalled beat");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> head_ff != tail_ff)
      else $error("pop from empty queue");

   a_mark_once: assert property (@(posedge clock) disable iff (reset)
      (cmd.nb_chk && stat.nb_free) |-> $past(cmd.nb_rd))
      else $error("neighbor marked without a fresh read");

endmodule
